// ----- design/fat_cluster_chain_walker_top_assert.svh -----
`ifndef FAT_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_WALKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FCCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define FCCW_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FCCW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FCCW_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- design/fccw_pkg.sv -----
package fccw_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 4096;
   localparam int MAX_CHAIN_DEFAULT     = 64;

   localparam int CLUSTER_W   = 16;
   localparam int ADDR_W      = 37;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CLUSTER_W-1:0] END_MARK   = 16'hFFF8;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA = 16'd2;

   localparam logic [15:0] RESERVED_SECTORS_RESET    = 16'd1;
   localparam logic [7:0]  TABLE_COPIES_RESET        = 8'd2;
   localparam logic [15:0] TABLE_SECTORS_RESET       = 16'd32;
   localparam logic [12:0] BYTES_PER_SECTOR_RESET    = 13'd512;
   localparam logic [7:0]  SECTORS_PER_CLUSTER_RESET = 8'd4;
   localparam logic [15:0] ROOT_ENTRY_COUNT_RESET    = 16'd512;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_WALK = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RESERVED_SECTORS    = 3'd0,
      CSR_TABLE_COPIES        = 3'd1,
      CSR_TABLE_SECTORS       = 3'd2,
      CSR_BYTES_PER_SECTOR    = 3'd3,
      CSR_SECTORS_PER_CLUSTER = 3'd4,
      CSR_ROOT_ENTRY_COUNT    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_A,
      ST_BASE_B,
      ST_BASE_C,
      ST_LOOK,
      ST_MUL,
      ST_ADD
   } state_type;

   typedef struct packed {
      logic load_entry;
      logic start_walk;
      logic base_a;
      logic base_b;
      logic base_c;
      logic look;
      logic mul;
      logic emit_good;
      logic emit_bad;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_end;
      logic cur_end;
      logic cur_bad;
      logic res_last;
      logic out_free;
   } ctrl_status_type;

endpackage

// ----- design/fccw_req_if.sv -----
interface fccw_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] entry_index;
   logic [15:0] entry_value;
   logic [15:0] start_cluster;

   modport source (
      output valid, command, entry_index, entry_value, start_cluster,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, entry_value, start_cluster,
      output ready
   );
endinterface

// ----- design/fccw_rsp_if.sv -----
interface fccw_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cluster;
   logic [15:0] next_cluster;
   logic [36:0] byte_address;
   logic        last;
   logic        bad_cluster;
   logic        truncated;

   modport source (
      output valid, cluster, next_cluster, byte_address, last, bad_cluster, truncated,
      input  ready
   );
   modport sink (
      input  valid, cluster, next_cluster, byte_address, last, bad_cluster, truncated,
      output ready
   );
endinterface

// ----- design/fccw_controller.sv -----
module fccw_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   output logic                     req_ready,
   output fccw_pkg::ctrl_cmd_type    cmd,
   input  fccw_pkg::ctrl_status_type status
);
   import fccw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load_entry = 1'b1;
               end else begin
                  cmd.start_walk = 1'b1;
                  if (!status.start_end) begin
                     state_in = ST_BASE_A;
                  end
               end
            end
         end
         ST_BASE_A: begin
            cmd.base_a = 1'b1;
            state_in   = ST_BASE_B;
         end
         ST_BASE_B: begin
            cmd.base_b = 1'b1;
            state_in   = ST_BASE_C;
         end
         ST_BASE_C: begin
            cmd.base_c = 1'b1;
            state_in   = ST_LOOK;
         end
         ST_LOOK: begin
            if (status.cur_end) begin
               state_in = ST_IDLE;
            end else if (status.cur_bad) begin
               if (status.out_free) begin
                  cmd.emit_bad = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.look = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (status.out_free) begin
               cmd.emit_good = 1'b1;
               cmd.advance   = 1'b1;
               if (status.res_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/fccw_datapath.sv -----
module fccw_datapath #(
   parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int MAX_CHAIN     = fccw_pkg::MAX_CHAIN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fccw_pkg::ctrl_cmd_type             cmd,
   output fccw_pkg::ctrl_status_type          status,
   input  logic                              csr_write_enable,
   input  logic [fccw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fccw_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [fccw_pkg::CLUSTER_W-1:0]    req_entry_index,
   input  logic [fccw_pkg::CLUSTER_W-1:0]    req_entry_value,
   input  logic [fccw_pkg::CLUSTER_W-1:0]    req_start_cluster,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [fccw_pkg::CLUSTER_W-1:0]    rsp_cluster,
   output logic [fccw_pkg::CLUSTER_W-1:0]    rsp_next_cluster,
   output logic [fccw_pkg::ADDR_W-1:0]       rsp_byte_address,
   output logic                              rsp_last,
   output logic                              rsp_bad_cluster,
   output logic                              rsp_truncated
);
   import fccw_pkg::*;

   localparam int AW     = $clog2(TABLE_ENTRIES);
   localparam int STEP_W = $clog2(MAX_CHAIN + 1);
   localparam logic [CLUSTER_W:0]  TABLE_LIMIT = (CLUSTER_W + 1)'(TABLE_ENTRIES);
   localparam logic [STEP_W-1:0]   CHAIN_CAP   = STEP_W'(MAX_CHAIN);

   logic [15:0] reserved_sectors_ff;
   logic [7:0]  table_copies_ff;
   logic [15:0] table_sectors_ff;
   logic [12:0] bytes_per_sector_ff;
   logic [7:0]  sectors_per_cluster_ff;
   logic [15:0] root_entry_count_ff;

   logic [CLUSTER_W-1:0] fat_table_mem [TABLE_ENTRIES];
   logic [CLUSTER_W-1:0] fat_rdata_ff;

   logic [CLUSTER_W-1:0] walk_cluster_ff;
   logic [STEP_W-1:0]    walk_steps_ff;

   logic [23:0]         table_prod_ff;
   logic [24:0]         sector_sum;
   logic [ADDR_W-1:0]   base_mul_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic [CLUSTER_W-1:0] cluster_off;
   logic [23:0]         ofs_a_ff;
   logic [ADDR_W-1:0]   ofs_b_ff;

   logic                 rsp_valid_ff;
   logic [CLUSTER_W-1:0] rsp_cluster_ff;
   logic [CLUSTER_W-1:0] rsp_next_cluster_ff;
   logic [ADDR_W-1:0]    rsp_byte_address_ff;
   logic                 rsp_last_ff;
   logic                 rsp_bad_cluster_ff;
   logic                 rsp_truncated_ff;

   logic                 next_end;
   logic                 step_cap;
   logic [STEP_W-1:0]    steps_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_sectors_ff    <= RESERVED_SECTORS_RESET;
         table_copies_ff        <= TABLE_COPIES_RESET;
         table_sectors_ff       <= TABLE_SECTORS_RESET;
         bytes_per_sector_ff    <= BYTES_PER_SECTOR_RESET;
         sectors_per_cluster_ff <= SECTORS_PER_CLUSTER_RESET;
         root_entry_count_ff    <= ROOT_ENTRY_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESERVED_SECTORS:    reserved_sectors_ff    <= csr_write_data;
            CSR_TABLE_COPIES:        table_copies_ff        <= csr_write_data[7:0];
            CSR_TABLE_SECTORS:       table_sectors_ff       <= csr_write_data;
            CSR_BYTES_PER_SECTOR:    bytes_per_sector_ff    <= csr_write_data[12:0];
            CSR_SECTORS_PER_CLUSTER: sectors_per_cluster_ff <= csr_write_data[7:0];
            CSR_ROOT_ENTRY_COUNT:    root_entry_count_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // allocation table, loads only while idle
   always_ff @(posedge clock) begin
      if (cmd.load_entry && ({1'b0, req_entry_index} < TABLE_LIMIT)) begin
         fat_table_mem[req_entry_index[AW-1:0]] <= req_entry_value;
      end
      fat_rdata_ff <= fat_table_mem[walk_cluster_ff[AW-1:0]];
   end

   assign steps_inc = walk_steps_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_cluster_ff <= '0;
         walk_steps_ff   <= '0;
      end else begin
         if (cmd.start_walk) begin
            walk_cluster_ff <= req_start_cluster;
            walk_steps_ff   <= '0;
         end else begin
            if (cmd.advance) begin
               walk_cluster_ff <= fat_rdata_ff;
            end
            if (cmd.emit_good || cmd.emit_bad) begin
               walk_steps_ff <= steps_inc;
            end
         end
      end
   end

   // data region base, then per-cluster offset
   assign sector_sum  = {1'b0, table_prod_ff} + {9'd0, reserved_sectors_ff};
   assign cluster_off = walk_cluster_ff - FIRST_DATA;

   always_ff @(posedge clock) begin
      if (cmd.base_a) begin
         table_prod_ff <= {16'd0, table_copies_ff} * {8'd0, table_sectors_ff};
      end
      if (cmd.base_b) begin
         base_mul_ff <= {12'd0, sector_sum} * {24'd0, bytes_per_sector_ff};
      end
      if (cmd.base_c) begin
         base_ff <= base_mul_ff + {16'd0, root_entry_count_ff, 5'd0};
      end
      if (cmd.look) begin
         ofs_a_ff <= {8'd0, cluster_off} * {16'd0, sectors_per_cluster_ff};
      end
      if (cmd.mul) begin
         ofs_b_ff <= {13'd0, ofs_a_ff} * {24'd0, bytes_per_sector_ff};
      end
   end

   assign next_end = (fat_rdata_ff >= END_MARK);
   assign step_cap = (steps_inc == CHAIN_CAP);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_good || cmd.emit_bad) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_good) begin
         rsp_cluster_ff      <= walk_cluster_ff;
         rsp_next_cluster_ff <= fat_rdata_ff;
         rsp_byte_address_ff <= base_ff + ofs_b_ff;
         rsp_last_ff         <= next_end || step_cap;
         rsp_bad_cluster_ff  <= 1'b0;
         rsp_truncated_ff    <= !next_end && step_cap;
      end else if (cmd.emit_bad) begin
         rsp_cluster_ff      <= walk_cluster_ff;
         rsp_next_cluster_ff <= '0;
         rsp_byte_address_ff <= '0;
         rsp_last_ff         <= 1'b1;
         rsp_bad_cluster_ff  <= 1'b1;
         rsp_truncated_ff    <= 1'b0;
      end
   end

   always_comb begin
      status.start_end = (req_start_cluster >= END_MARK);
      status.cur_end   = (walk_cluster_ff >= END_MARK);
      status.cur_bad   = (walk_cluster_ff < FIRST_DATA) ||
                         ({1'b0, walk_cluster_ff} >= TABLE_LIMIT);
      status.res_last  = next_end || step_cap;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cluster      = rsp_cluster_ff;
   assign rsp_next_cluster = rsp_next_cluster_ff;
   assign rsp_byte_address = rsp_byte_address_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_bad_cluster  = rsp_bad_cluster_ff;
   assign rsp_truncated    = rsp_truncated_ff;

endmodule

// ----- design/fat_cluster_chain_walker_top.sv -----
// table load: no result; the controller stays idle, so the next request is taken the cycle after
// walk: an accept, the data region base in states BASE_A, BASE_B and BASE_C, then per cluster
//   the states LOOK, MUL and ADD; a result is emitted in ADD, or in LOOK for a bad cluster, and
//   waits there while the output register is full and not taken; one output register
// reset: synchronous, active high; controller, walk state, output valid and configuration
//   registers return to their defaults; the allocation table is not cleared
`include "fat_cluster_chain_walker_top_assert.svh"

module fat_cluster_chain_walker_top #(
   parameter int TABLE_ENTRIES = fccw_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int MAX_CHAIN     = fccw_pkg::MAX_CHAIN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [fccw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fccw_pkg::CSR_DATA_W-1:0]  csr_write_data,
   fccw_req_if.sink                         req_chan,
   fccw_rsp_if.source                       rsp_chan
);
   import fccw_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   fccw_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .cmd         (cmd),
      .status      (status)
   );

   fccw_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CHAIN     (MAX_CHAIN)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_entry_index   (req_chan.entry_index),
      .req_entry_value   (req_chan.entry_value),
      .req_start_cluster (req_chan.start_cluster),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_cluster       (rsp_chan.cluster),
      .rsp_next_cluster  (rsp_chan.next_cluster),
      .rsp_byte_address  (rsp_chan.byte_address),
      .rsp_last          (rsp_chan.last),
      .rsp_bad_cluster   (rsp_chan.bad_cluster),
      .rsp_truncated     (rsp_chan.truncated)
   );

   `FCCW_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit_good || cmd.emit_bad, status.out_free, "result loaded over a waiting transaction")
   `FCCW_ASSERT_IMPLY(a_bad_final, clock, reset, rsp_chan.valid && rsp_chan.bad_cluster, rsp_chan.last && (rsp_chan.next_cluster == '0) && !rsp_chan.truncated, "bad cluster result not final")
   `FCCW_ASSERT_IMPLY(a_trunc_final, clock, reset, rsp_chan.valid && rsp_chan.truncated, rsp_chan.last && !rsp_chan.bad_cluster && (rsp_chan.next_cluster < END_MARK), "truncated result malformed")
   `FCCW_ASSERT_NEVER(a_cmd_excl, clock, reset, (cmd.load_entry || cmd.start_walk) && (cmd.emit_good || cmd.emit_bad || cmd.advance), "request taken during a walk")

endmodule
